// ===== rtl/core/upe_pkg.sv =====
`default_nettype none

package upe_pkg;

    // Longest UTF-8 sequence for a 31-bit code point under the original scheme.
    localparam int MAX_BYTES = 6;
    localparam int BIDX_W    = 3;
    localparam int CP_W      = 31;
    localparam int CHAR_W    = 7;

    // Depth of the queue between classifier and emitter.
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    localparam logic [CP_W-1:0] CP_ASCII_LIMIT = 31'h0000_0080;
    localparam logic [CP_W-1:0] CP_LEN2_LIMIT  = 31'h0000_0800;
    localparam logic [CP_W-1:0] CP_LEN3_LIMIT  = 31'h0001_0000;
    localparam logic [CP_W-1:0] CP_LEN4_LIMIT  = 31'h0020_0000;
    localparam logic [CP_W-1:0] CP_LEN5_LIMIT  = 31'h0400_0000;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 7'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 7'd43;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 7'd37;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'd65;

    // One classified code point: either a single character passed as is,
    // or a run of bytes each to be written as %HH.
    typedef struct packed {
        logic                           esc;
        logic [BIDX_W-1:0]              nbytes;
        logic [MAX_BYTES-1:0][7:0]      bytes;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic needs_escape(input logic [CHAR_W-1:0] c);
        needs_escape = (c >= 7'd33  && c <= 7'd35) ||
                       (c >= 7'd37  && c <= 7'd44) ||
                       (c >= 7'd58  && c <= 7'd64) ||
                       (c == 7'd91) || (c == 7'd96) ||
                       (c >= 7'd93  && c <= 7'd94) ||
                       (c >= 7'd123);
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            hex_char = CH_ZERO + {3'b000, v};
        else
            hex_char = CH_UPPER_A + {3'b000, v} - 7'd10;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/upe_front.sv =====
`default_nettype none

module upe_front
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cp_valid,
    output logic                          cp_ready,
    input  wire logic [30:0]              code_point,
    output logic                          push,
    output upe_pkg::desc_t                push_desc,
    input  wire upe_pkg::q_status_t       q_status
);
    import upe_pkg::*;

    logic  front_valid_reg;
    logic  front_valid_next;
    desc_t desc_reg;
    desc_t desc_next;

    assign push      = front_valid_reg && !q_status.full;
    assign cp_ready  = !front_valid_reg || !q_status.full;
    assign push_desc = desc_reg;

    always_comb
    begin
        desc_next = '0;
        if (code_point < CP_ASCII_LIMIT)
        begin
            desc_next.nbytes = 3'd1;
            if (needs_escape(code_point[6:0]))
            begin
                desc_next.esc      = 1'b1;
                desc_next.bytes[0] = {1'b0, code_point[6:0]};
            end
            else if (code_point[6:0] == CH_SPACE)
            begin
                desc_next.bytes[0] = {1'b0, CH_PLUS};
            end
            else
            begin
                desc_next.bytes[0] = {1'b0, code_point[6:0]};
            end
        end
        else
        begin
            desc_next.esc = 1'b1;
            if (code_point < CP_LEN2_LIMIT)
            begin
                desc_next.nbytes   = 3'd2;
                desc_next.bytes[0] = {3'b110, code_point[10:6]};
                desc_next.bytes[1] = {2'b10, code_point[5:0]};
            end
            else if (code_point < CP_LEN3_LIMIT)
            begin
                desc_next.nbytes   = 3'd3;
                desc_next.bytes[0] = {4'b1110, code_point[15:12]};
                desc_next.bytes[1] = {2'b10, code_point[11:6]};
                desc_next.bytes[2] = {2'b10, code_point[5:0]};
            end
            else if (code_point < CP_LEN4_LIMIT)
            begin
                desc_next.nbytes   = 3'd4;
                desc_next.bytes[0] = {5'b11110, code_point[20:18]};
                desc_next.bytes[1] = {2'b10, code_point[17:12]};
                desc_next.bytes[2] = {2'b10, code_point[11:6]};
                desc_next.bytes[3] = {2'b10, code_point[5:0]};
            end
            else if (code_point < CP_LEN5_LIMIT)
            begin
                desc_next.nbytes   = 3'd5;
                desc_next.bytes[0] = {6'b111110, code_point[25:24]};
                desc_next.bytes[1] = {2'b10, code_point[23:18]};
                desc_next.bytes[2] = {2'b10, code_point[17:12]};
                desc_next.bytes[3] = {2'b10, code_point[11:6]};
                desc_next.bytes[4] = {2'b10, code_point[5:0]};
            end
            else
            begin
                desc_next.nbytes   = 3'd6;
                desc_next.bytes[0] = {7'b1111110, code_point[30]};
                desc_next.bytes[1] = {2'b10, code_point[29:24]};
                desc_next.bytes[2] = {2'b10, code_point[23:18]};
                desc_next.bytes[3] = {2'b10, code_point[17:12]};
                desc_next.bytes[4] = {2'b10, code_point[11:6]};
                desc_next.bytes[5] = {2'b10, code_point[5:0]};
            end
        end
    end

    always_comb
    begin
        if (cp_valid && cp_ready)
            front_valid_next = 1'b1;
        else if (push)
            front_valid_next = 1'b0;
        else
            front_valid_next = front_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cp_valid && cp_ready)
            desc_reg <= desc_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/upe_queue.sv =====
`default_nettype none

module upe_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire upe_pkg::desc_t       push_desc,
    input  wire logic                 pop,
    output upe_pkg::desc_t            head_desc,
    output upe_pkg::q_status_t        q_status
);
    import upe_pkg::*;

    desc_t               mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign q_status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_desc      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_desc;
    end

endmodule

`default_nettype wire

// ===== rtl/core/upe_back.sv =====
`default_nettype none

module upe_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire upe_pkg::desc_t       head_desc,
    input  wire upe_pkg::q_status_t   q_status,
    output logic                      pop,
    output logic                      char_valid,
    input  wire logic                 char_ready,
    output logic [6:0]                out_char,
    output logic                      last_char
);
    import upe_pkg::*;

    localparam logic [1:0] PH_PCT = 2'd0;
    localparam logic [1:0] PH_HI  = 2'd1;
    localparam logic [1:0] PH_LO  = 2'd2;

    logic                cur_valid_reg;
    logic                cur_valid_next;
    desc_t               cur_reg;
    logic [BIDX_W-1:0]   bidx_reg;
    logic [BIDX_W-1:0]   bidx_next;
    logic [1:0]          phase_reg;
    logic [1:0]          phase_next;
    logic                char_valid_reg;
    logic                char_valid_next;
    logic [CHAR_W-1:0]   char_reg;
    logic                last_reg;

    logic                emit;
    logic                load;
    logic                is_last;
    logic [7:0]          cur_byte;
    logic [CHAR_W-1:0]   ch;

    assign cur_byte = cur_reg.bytes[bidx_reg];

    always_comb
    begin
        if (!cur_reg.esc)
        begin
            ch      = cur_byte[6:0];
            is_last = 1'b1;
        end
        else
        begin
            is_last = (phase_reg == PH_LO) && (bidx_reg == cur_reg.nbytes - 3'd1);
            case (phase_reg)
                PH_PCT:  ch = CH_PERCENT;
                PH_HI:   ch = hex_char(cur_byte[7:4]);
                PH_LO:   ch = hex_char(cur_byte[3:0]);
                default: ch = CH_PERCENT;
            endcase
        end
    end

    assign emit = cur_valid_reg && (!char_valid_reg || char_ready);
    assign load = !cur_valid_reg || (emit && is_last);
    assign pop  = load && !q_status.empty;

    always_comb
    begin
        cur_valid_next  = cur_valid_reg;
        bidx_next       = bidx_reg;
        phase_next      = phase_reg;
        char_valid_next = char_valid_reg;

        if (emit)
        begin
            char_valid_next = 1'b1;
            if (phase_reg == PH_LO)
            begin
                phase_next = PH_PCT;
                bidx_next  = bidx_reg + 1'b1;
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
        else if (char_ready)
        begin
            char_valid_next = 1'b0;
        end

        if (load)
        begin
            cur_valid_next = !q_status.empty;
            bidx_next      = '0;
            phase_next     = PH_PCT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            bidx_reg       <= '0;
            phase_reg      <= PH_PCT;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg  <= cur_valid_next;
            bidx_reg       <= bidx_next;
            phase_reg      <= phase_next;
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head_desc;
        if (emit)
        begin
            char_reg <= ch;
            last_reg <= is_last;
        end
    end

    assign char_valid = char_valid_reg;
    assign out_char   = char_reg;
    assign last_char  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/url_percent_encoder.sv =====
// URL encoder for a stream of Unicode code points.
// Input channel: code_point with cp_valid / cp_ready, one 31-bit code point per transaction.
// Output channel: out_char and last_char with char_valid / char_ready, one ASCII character
// per transaction; last_char marks the final character written for a code point.
// Plain ASCII gives one character, space gives '+', reserved ASCII gives %HH, and code points
// of 0x80 and above are UTF-8 encoded (two to six bytes), each byte written as %HH.
// A code point therefore gives 1, 3, 6, 9, 12, 15 or 18 characters on the output side:
// the emitter writes one character per cycle unless char_ready stalls it, and that sets
// the throughput. The classifier register is loaded at the accepting edge itself. From
// there the first character passes the queue write, the emitter descriptor register and
// the output register before it is on the port.
// The classifier and the emitter are separated by a two-entry queue, so new code points
// keep being taken while earlier ones are still being written out.
// When char_ready is held low the output register holds its character, the emitter stops,
// the queue fills and then cp_ready drops.
// Reset clears every valid flag and the queue pointers; no item survives reset.
`default_nettype none

module url_percent_encoder
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cp_valid,
    output logic                cp_ready,
    input  wire logic [30:0]    code_point,
    output logic                char_valid,
    input  wire logic           char_ready,
    output logic [6:0]          out_char,
    output logic                last_char
);
    import upe_pkg::*;

    logic      push;
    logic      pop;
    desc_t     push_desc;
    desc_t     head_desc;
    q_status_t q_status;

    // Front: takes code points and turns them into byte descriptors.
    upe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .code_point (code_point),
        .push       (push),
        .push_desc  (push_desc),
        .q_status   (q_status)
    );

    // Queue decouples classification from character output.
    upe_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .head_desc  (head_desc),
        .q_status   (q_status)
    );

    // Back: walks each descriptor one character per cycle while char_ready does not stall it.
    upe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_desc  (head_desc),
        .q_status   (q_status),
        .pop        (pop),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .out_char   (out_char),
        .last_char  (last_char)
    );

`ifndef NO_ASSERTIONS
    // A literal '%' only ever opens an escape, so it never ends a group.
    a_pct_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && (out_char == CH_PERCENT) |-> !last_char)
        else $error("percent sign flagged as last character");

    // '+' only stands for a space and is always a group of its own.
    a_plus_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && (out_char == CH_PLUS) |-> last_char)
        else $error("plus sign not flagged as last character");

    // After a '%' is taken, the high hex digit follows at once.
    a_pct_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_ready && (out_char == CH_PERCENT)
        |=> char_valid && !last_char && (out_char != CH_PERCENT))
        else $error("escape not followed by a hex digit");

    // The classifier never writes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("queue overflow");
`endif

endmodule

`default_nettype wire
